// ===== rtl/vlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types and codes for the versioned lru object cache.
// ----------------------------------------------------------------------------
package vlc_pkg;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [63:0] version;
        logic [63:0] signature;
        logic [63:0] frame;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_DONE
    } t_state;

    localparam logic [1:0] OP_RESOLVE = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_STAT    = 2'd2;

    localparam logic [2:0] CNT_DYNAMIC   = 3'd0;
    localparam logic [2:0] CNT_PACKFAIL  = 3'd1;
    localparam logic [2:0] CNT_HITS      = 3'd2;
    localparam logic [2:0] CNT_MISSES    = 3'd3;
    localparam logic [2:0] CNT_UPDATES   = 3'd4;
    localparam logic [2:0] CNT_EVICTIONS = 3'd5;
    localparam logic [2:0] SEL_ENTRIES   = 3'd6;

    localparam int NUM_CNT = 6;

endpackage

// ===== rtl/vlc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_cell
// One cache entry of the rotating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module vlc_cell
    import vlc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  logic   i_clr,
    input  t_entry i_prev,
    output t_entry o_entry
);

    logic   r_valid;
    t_entry r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_prev;
        end
    end

    always_comb begin
        o_entry       = r_data;
        o_entry.valid = r_valid;
    end

endmodule

// ===== rtl/vlc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_ctrl
// Sequencer: scans the ring at its head, decides, rewrites on a second pass.
// ----------------------------------------------------------------------------
module vlc_ctrl
    import vlc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [6:0]    i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_op,
    input  logic [63:0]   i_identity,
    input  logic          i_id_avail,
    input  logic [63:0]   i_version,
    input  logic [63:0]   i_signature,
    input  logic [63:0]   i_frame,
    input  logic          i_build_ok,
    input  logic          i_packed_req,
    input  logic          i_packed_ok,
    input  logic [2:0]    i_stat_sel,
    input  t_entry        i_head,
    output t_entry        o_feedback,
    output logic          o_shift,
    output logic          o_clr,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_ok,
    output logic          o_hit,
    output logic          o_cached,
    output logic [5:0]    o_slot,
    output logic          o_evicted,
    output logic [63:0]   o_evicted_identity,
    output logic [6:0]    o_entry_count,
    output logic [63:0]   o_stat_value
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > 7) ? CW : 7;

    t_state r_state, n_state;
    logic [6:0]    r_cap;
    logic [CW-1:0] r_count;
    logic [63:0]   r_cnt [NUM_CNT];
    logic [IW-1:0] r_idx;

    // held request
    logic [63:0] r_id, r_ver, r_sig, r_frm;
    logic        r_build, r_pfail;

    // scan results
    logic          r_found, r_fmatch, r_free, r_lru;
    logic [IW-1:0] r_fidx, r_freeidx, r_lruidx;
    logic [63:0]   r_lrufrm, r_lrukey;

    // write plan
    logic          r_wr, r_wr_full, r_ev;
    logic [IW-1:0] r_wr_idx, r_ev_idx;

    // result
    logic          r_ok, r_hit, r_cached, r_evd;
    logic [IW-1:0] r_slot;
    logic [63:0]   r_evid, r_stat;

    // output register
    logic          r_ovalid, r_o_ok, r_o_hit, r_o_cached, r_o_ev;
    logic [5:0]    r_o_slot;
    logic [63:0]   r_o_evid, r_o_stat;
    logic [6:0]    r_o_count;

    logic [EW-1:0] eff_cap, cap_x;
    logic          accept, cacheable, load_out, evict_now;
    logic [IW-1:0] target;
    logic [IW+5:0] slot_x;
    logic [CW+6:0] count_x;

    always_comb begin
        cap_x = EW'(r_cap);
        if (r_cap == 7'd0) begin
            eff_cap = EW'(1);
        end else if (cap_x > EW'(ENTRIES)) begin
            eff_cap = EW'(ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
    end

    assign accept    = i_in_valid && o_in_ready;
    assign cacheable = i_id_avail && (i_identity != 64'd0) && (i_version != 64'd0);
    assign load_out  = (r_state == S_DONE) && (!r_ovalid || i_out_ready);
    assign evict_now = (EW'(r_count) >= eff_cap) && r_lru;
    assign target    = (evict_now && (!r_free || r_lruidx < r_freeidx)) ? r_lruidx
                                                                        : r_freeidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_shift    = 1'b0;
        o_clr      = 1'b0;
        o_feedback = i_head;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_clr = (i_op == OP_CLEAR);
                    if (i_op == OP_RESOLVE && cacheable) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_shift = 1'b1;
                if (r_idx == '0) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = r_wr ? S_WRITE : S_DONE;
                if (r_found && r_fmatch) begin
                    n_state = S_WRITE;
                end else if (r_build) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                o_shift = 1'b1;
                if (r_wr && r_idx == r_wr_idx) begin
                    if (r_wr_full) begin
                        o_feedback = '{1'b1, r_id, r_ver, r_sig, r_frm};
                    end else begin
                        o_feedback.frame = r_frm;
                    end
                end else if (r_ev && r_idx == r_ev_idx) begin
                    o_feedback.valid = 1'b0;
                end
                if (r_idx == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ring visits slots from the top down, so later candidates are lower slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 7'd64;
            r_count <= '0;
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= 64'd0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (accept) begin
                r_idx <= IW'(ENTRIES - 1);
                r_id  <= i_identity;
                r_ver <= i_version;
                r_sig <= i_signature;
                r_frm <= i_frame;
                r_build <= i_build_ok;
                r_pfail <= i_packed_req && !i_packed_ok;
                r_found <= 1'b0;
                r_free  <= 1'b0;
                r_lru   <= 1'b0;
                r_wr    <= 1'b0;
                r_ev    <= 1'b0;
                r_ok    <= 1'b0;
                r_hit   <= 1'b0;
                r_cached <= 1'b0;
                r_evd   <= 1'b0;
                r_slot  <= '0;
                r_evid  <= 64'd0;
                r_stat  <= 64'd0;
                case (i_op)
                    OP_CLEAR: begin
                        r_count <= '0;
                        for (int k = 0; k < NUM_CNT; k++) begin
                            r_cnt[k] <= 64'd0;
                        end
                    end
                    OP_STAT: begin
                        if (i_stat_sel < SEL_ENTRIES) begin
                            r_stat <= r_cnt[i_stat_sel];
                        end else if (i_stat_sel == SEL_ENTRIES) begin
                            r_stat <= 64'(r_count);
                        end
                    end
                    OP_RESOLVE: begin
                        if (!cacheable) begin
                            r_cnt[CNT_DYNAMIC] <= r_cnt[CNT_DYNAMIC] + 64'd1;
                            if (i_build_ok) begin
                                r_ok <= 1'b1;
                                if (i_packed_req && !i_packed_ok) begin
                                    r_cnt[CNT_PACKFAIL] <= r_cnt[CNT_PACKFAIL] + 64'd1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_WRITE && r_idx == '0) begin
                r_idx <= IW'(ENTRIES - 1);
            end else if (r_state == S_SCAN || r_state == S_WRITE) begin
                r_idx <= r_idx - IW'(1);
            end
            if (r_state == S_SCAN) begin
                if (i_head.valid && i_head.key == r_id) begin
                    r_found  <= 1'b1;
                    r_fidx   <= r_idx;
                    r_fmatch <= (i_head.version == r_ver) && (i_head.signature == r_sig);
                end
                if (!i_head.valid) begin
                    r_free    <= 1'b1;
                    r_freeidx <= r_idx;
                end
                if (i_head.valid && (!r_lru || i_head.frame <= r_lrufrm)) begin
                    r_lru    <= 1'b1;
                    r_lruidx <= r_idx;
                    r_lrufrm <= i_head.frame;
                    r_lrukey <= i_head.key;
                end
            end
            if (r_state == S_DECIDE) begin
                r_idx <= IW'(ENTRIES - 1);
                if (r_found && r_fmatch) begin
                    r_cnt[CNT_HITS] <= r_cnt[CNT_HITS] + 64'd1;
                    r_wr      <= 1'b1;
                    r_wr_full <= 1'b0;
                    r_wr_idx  <= r_fidx;
                    r_ok      <= 1'b1;
                    r_hit     <= 1'b1;
                    r_cached  <= 1'b1;
                    r_slot    <= r_fidx;
                end else if (r_build) begin
                    if (r_pfail) begin
                        r_cnt[CNT_PACKFAIL] <= r_cnt[CNT_PACKFAIL] + 64'd1;
                    end
                    r_cnt[CNT_MISSES] <= r_cnt[CNT_MISSES] + 64'd1;
                    r_wr      <= 1'b1;
                    r_wr_full <= 1'b1;
                    r_ok      <= 1'b1;
                    r_cached  <= 1'b1;
                    if (r_found) begin
                        r_cnt[CNT_UPDATES] <= r_cnt[CNT_UPDATES] + 64'd1;
                        r_wr_idx <= r_fidx;
                        r_slot   <= r_fidx;
                    end else begin
                        r_wr_idx <= target;
                        r_slot   <= target;
                        if (evict_now) begin
                            r_cnt[CNT_EVICTIONS] <= r_cnt[CNT_EVICTIONS] + 64'd1;
                            r_ev     <= 1'b1;
                            r_ev_idx <= r_lruidx;
                            r_evd    <= 1'b1;
                            r_evid   <= r_lrukey;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
            end
        end
    end

    assign slot_x  = {6'd0, r_slot};
    assign count_x = {7'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_ok     <= r_ok;
            r_o_hit    <= r_hit;
            r_o_cached <= r_cached;
            r_o_slot   <= slot_x[5:0];
            r_o_ev     <= r_evd;
            r_o_evid   <= r_evid;
            r_o_count  <= count_x[6:0];
            r_o_stat   <= r_stat;
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_ok               = r_o_ok;
    assign o_hit              = r_o_hit;
    assign o_cached           = r_o_cached;
    assign o_slot             = r_o_slot;
    assign o_evicted          = r_o_ev;
    assign o_evicted_identity = r_o_evid;
    assign o_entry_count      = r_o_count;
    assign o_stat_value       = r_o_stat;

endmodule

// ===== rtl/versioned_lru_object_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_lru_object_cache_core
// Fully associative versioned object cache with lru replacement.
// ----------------------------------------------------------------------------
// The entries sit in a ring of ENTRIES cells that rotates one step a cycle
// while a scan or write pass runs. A cacheable resolve is accepted, scans the
// whole ring for a key match, the lowest free slot and the least recently
// used entry, takes a decision, then rotates the ring once more to write the
// result back, and loads the output register. A miss that is not built skips
// the write rotation. Clear, counter reads, no-ops and uncacheable resolves
// go straight from acceptance to the output register. One beat is in work
// at a time; a finished result waits in the output register while the next
// beat is taken, and a result stalls until the previous one has been taken.
// Capacity writes arrive on i_cfg_wr_en and take effect at once, also for a
// beat in work that has not yet reached its decision.
module versioned_lru_object_cache_core
    import vlc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [6:0]   i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // identity, identity_available, content_version, signature, frame_id,
    // build_ok, packed_requested, packed_ok, zero pad
    input  logic [263:0] s_axis_tdata,
    // operation, stat_select
    input  logic [4:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ok, hit, cached, slot, evicted, evicted_identity, entry_count,
    // stat_value, zero pad
    output logic [151:0] m_axis_tdata
);

    t_entry ring [ENTRIES];
    t_entry fb;
    logic   shift, clr;
    logic   ok, hit, cached, evd;
    logic [5:0]  slot;
    logic [63:0] evid, stat;
    logic [6:0]  count;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        vlc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clr   (clr),
            .i_prev  ((k == 0) ? fb : ring[(k == 0) ? 0 : k - 1]),
            .o_entry (ring[k])
        );
    end

    vlc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (s_axis_tvalid),
        .o_in_ready         (s_axis_tready),
        .i_op               (s_axis_tuser[1:0]),
        .i_identity         (s_axis_tdata[63:0]),
        .i_id_avail         (s_axis_tdata[64]),
        .i_version          (s_axis_tdata[128:65]),
        .i_signature        (s_axis_tdata[192:129]),
        .i_frame            (s_axis_tdata[256:193]),
        .i_build_ok         (s_axis_tdata[257]),
        .i_packed_req       (s_axis_tdata[258]),
        .i_packed_ok        (s_axis_tdata[259]),
        .i_stat_sel         (s_axis_tuser[4:2]),
        .i_head             (ring[ENTRIES-1]),
        .o_feedback         (fb),
        .o_shift            (shift),
        .o_clr              (clr),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_ok               (ok),
        .o_hit              (hit),
        .o_cached           (cached),
        .o_slot             (slot),
        .o_evicted          (evd),
        .o_evicted_identity (evid),
        .o_entry_count      (count),
        .o_stat_value       (stat)
    );

    assign m_axis_tdata = {7'd0, stat, count, evid, evd, slot, cached, hit, ok};

endmodule

// ===== tb/sv/versioned_lru_object_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_lru_object_cache_checker
// Watches both stream channels of the cache core, keeps its own model of the
// table, counters and capacity, and compares every output beat field by field.
// ----------------------------------------------------------------------------
module versioned_lru_object_cache_checker
    import vlc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [6:0]   i_cfg_wr_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [263:0] i_s_tdata,
    input  logic [4:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [151:0] i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        bit        ok;
        bit        hit;
        bit        cached;
        bit [5:0]  slot;
        bit        evicted;
        bit [63:0] evicted_id;
        bit [6:0]  entry_count;
        bit [63:0] stat_value;
    } t_lookup_result;

    bit        slot_valid [64];
    bit [63:0] slot_key   [64];
    bit [63:0] slot_ver   [64];
    bit [63:0] slot_sig   [64];
    bit [63:0] slot_frame [64];
    bit [6:0]  live_count;
    bit [63:0] event_cnt  [NUM_CNT];
    bit [6:0]  capacity;

    t_lookup_result expected_q[$];

    assign o_pending = expected_q.size();

    task automatic wipe_table();
        for (int i = 0; i < 64; i++) slot_valid[i] = 0;
        for (int i = 0; i < NUM_CNT; i++) event_cnt[i] = '0;
        live_count = '0;
    endtask

    task automatic resolve_beat(input logic [263:0] d, input logic [4:0] u);
        t_lookup_result r;
        bit [1:0]  op;
        bit [2:0]  sel;
        bit [63:0] id, ver, sig, frame;
        bit        avail, build_ok, pk_req, pk_ok;
        int        found, oldest, target, cap_eff;
        op       = u[1:0];
        sel      = u[4:2];
        id       = d[63:0];
        avail    = d[64];
        ver      = d[128:65];
        sig      = d[192:129];
        frame    = d[256:193];
        build_ok = d[257];
        pk_req   = d[258];
        pk_ok    = d[259];
        r = '{default: 0};
        if (op == OP_CLEAR) begin
            wipe_table();
        end else if (op == OP_STAT) begin
            if (sel < NUM_CNT) r.stat_value = event_cnt[sel];
            else if (sel == SEL_ENTRIES) r.stat_value = 64'(live_count);
        end else if (op == OP_RESOLVE) begin
            if (!(avail && id != 0 && ver != 0)) begin
                event_cnt[CNT_DYNAMIC]++;
                if (build_ok) begin
                    if (pk_req && !pk_ok) event_cnt[CNT_PACKFAIL]++;
                    r.ok = 1;
                end
            end else begin
                found = -1;
                for (int i = 0; i < 64; i++)
                    if (found < 0 && slot_valid[i] && slot_key[i] == id) found = i;
                if (found >= 0 && slot_ver[found] == ver && slot_sig[found] == sig) begin
                    slot_frame[found] = frame;
                    event_cnt[CNT_HITS]++;
                    r.ok = 1; r.hit = 1; r.cached = 1; r.slot = 6'(found);
                end else if (build_ok) begin
                    if (pk_req && !pk_ok) event_cnt[CNT_PACKFAIL]++;
                    event_cnt[CNT_MISSES]++;
                    if (found >= 0) begin
                        event_cnt[CNT_UPDATES]++;
                        target = found;
                    end else begin
                        cap_eff = (capacity == 0) ? 1 : (capacity > 64 ? 64 : capacity);
                        if (live_count >= cap_eff) begin
                            oldest = -1;
                            for (int i = 0; i < 64; i++)
                                if (slot_valid[i] &&
                                    (oldest < 0 || slot_frame[i] < slot_frame[oldest]))
                                    oldest = i;
                            if (oldest >= 0) begin
                                r.evicted    = 1;
                                r.evicted_id = slot_key[oldest];
                                slot_valid[oldest] = 0;
                                live_count--;
                                event_cnt[CNT_EVICTIONS]++;
                            end
                        end
                        target = -1;
                        for (int i = 0; i < 64; i++)
                            if (target < 0 && !slot_valid[i]) target = i;
                        slot_valid[target] = 1;
                        live_count++;
                    end
                    slot_key[target]   = id;
                    slot_ver[target]   = ver;
                    slot_sig[target]   = sig;
                    slot_frame[target] = frame;
                    r.ok = 1; r.cached = 1; r.slot = 6'(target);
                end
            end
        end
        r.entry_count = live_count;
        expected_q = {expected_q, r};
    endtask

    task automatic check_field(input string nm, input bit [63:0] exp_v, input bit [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, nm, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task automatic compare_beat(input logic [151:0] d);
        t_lookup_result e;
        if (expected_q.size() == 0) begin
            $display("%0t: output beat with nothing expected, actual %0h", $time, d);
            o_fail_count++;
        end else begin
            e = expected_q.pop_front();
            check_field("ok",               64'(e.ok),          64'(d[0]));
            check_field("hit",              64'(e.hit),         64'(d[1]));
            check_field("cached",           64'(e.cached),      64'(d[2]));
            check_field("slot",             64'(e.slot),        64'(d[8:3]));
            check_field("evicted",          64'(e.evicted),     64'(d[9]));
            check_field("evicted_identity", e.evicted_id,       d[73:10]);
            check_field("entry_count",      64'(e.entry_count), 64'(d[80:74]));
            check_field("stat_value",       e.stat_value,       d[144:81]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_table();
            capacity = 7'd64;
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) compare_beat(i_m_tdata);
            if (i_cfg_wr_en) capacity = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) resolve_beat(i_s_tdata, i_s_tuser);
        end
    end

endmodule

// ===== tb/sv/tb_versioned_lru_object_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_versioned_lru_object_cache_core
// Drives directed and random lookups, clears and counter reads into the cache
// core across several capacities and handshake stall patterns; the checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_versioned_lru_object_cache_core;
    import vlc_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int DRAIN_CYCLES = 2 * 64 + 12;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_wr_en = 0;
    logic [6:0]   i_cfg_wr_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata = '0;
    logic [4:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [151:0] m_axis_tdata;
    int           fail_count;
    int           pending;

    int           tx_idle_pct;
    int           rx_idle_pct;
    int           key_range;
    bit [63:0]    frame_ctr;

    always #5 i_clk = ~i_clk;

    versioned_lru_object_cache_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    versioned_lru_object_cache_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input bit [1:0] op, input bit [63:0] id, input bit avail,
                             input bit [63:0] ver, input bit [63:0] sig,
                             input bit [63:0] frame, input bit bok, input bit preq,
                             input bit pok, input bit [2:0] sel);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata  = {4'b0, pok, preq, bok, frame, sig, ver, avail, id};
        s_axis_tuser  = {sel, op};
        // ready only follows the state register, so it is settled at the falling edge
        while (!s_axis_tready) @(negedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 0;
    endtask

    task automatic resolve(input bit [63:0] id, input bit [63:0] ver, input bit [63:0] sig,
                           input bit bok);
        frame_ctr++;
        send_beat(OP_RESOLVE, id, 1, ver, sig, frame_ctr, bok, 1'($urandom), 1'($urandom), 0);
    endtask

    task automatic random_beat();
        int        r;
        bit [1:0]  op;
        bit [63:0] id, ver, sig, frame;
        r = $urandom_range(99);
        op = (r < 2) ? OP_CLEAR : (r < 10) ? OP_STAT : (r < 13) ? OP_NOP : OP_RESOLVE;
        r = $urandom_range(99);
        id = (r < 80) ? 64'($urandom_range(key_range, 1)) : (r < 85) ? 64'd0 : rand64();
        r = $urandom_range(99);
        ver = (r < 85) ? 64'($urandom_range(3, 1)) : (r < 90) ? 64'd0 : rand64();
        r = $urandom_range(99);
        sig = (r < 90) ? 64'($urandom_range(2)) : rand64();
        // mostly rising stamps with ties, now and then a wild one
        frame_ctr += $urandom_range(2);
        frame = ($urandom_range(99) < 10) ? rand64() : frame_ctr;
        send_beat(op, id, $urandom_range(99) < 95, ver, sig, frame,
                  $urandom_range(99) < 90, 1'($urandom), 1'($urandom), 3'($urandom));
    endtask

    task automatic write_capacity(input bit [6:0] value);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   = 1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 0;
    endtask

    initial begin
        #5ms;
        $display("versioned_lru_object_cache_core test failed");
        $finish;
    end

    initial begin
        bit [6:0] caps [8] = '{7'd3, 7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd70, 7'd5};
        int       keys [8] = '{6, 4, 3, 100, 90, 90, 100, 12};
        tx_idle_pct = 11;
        rx_idle_pct = 81;
        key_range   = 8;
        frame_ctr   = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: counters at zero, no-op, uncacheable forms, extremes
        for (int s = 0; s < 8; s++)
            send_beat(OP_STAT, 0, 0, 0, 0, 0, 0, 0, 0, 3'(s));
        send_beat(OP_NOP, '1, 1, '1, '1, '1, 1, 1, 1, 3'd7);
        send_beat(OP_RESOLVE, 64'd5, 0, 64'd1, 0, 0, 1, 1, 0, 0);
        send_beat(OP_RESOLVE, 64'd0, 1, 64'd1, 0, 0, 0, 0, 0, 0);
        send_beat(OP_RESOLVE, 64'd5, 1, 64'd0, 0, 0, 1, 0, 1, 0);
        resolve('1, '1, '1, 1);
        resolve('1, '1, '1, 1);
        resolve('1, '1, 64'd7, 0);
        resolve('1, 64'd2, 64'd7, 1);
        resolve(64'd9, 64'd1, 64'd0, 1);
        send_beat(OP_RESOLVE, 64'd9, 1, 64'd1, 0, '1, 1, 1, 0, 0);
        for (int s = 0; s < 7; s++)
            send_beat(OP_STAT, 0, 0, 0, 0, 0, 0, 0, 0, 3'(s));
        send_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(OP_STAT, 0, 0, 0, 0, 0, 0, 0, 0, SEL_ENTRIES);

        for (int ph = 0; ph < 8; ph++) begin
            write_capacity(caps[ph]);
            key_range = keys[ph];
            if (ph == 3) begin
                tx_idle_pct = 81;
                rx_idle_pct = 11;
            end else if (ph == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            repeat (100) random_beat();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("versioned_lru_object_cache_core test passed");
        end else begin
            $display("versioned_lru_object_cache_core test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vlc_pkg.sv
rtl/vlc_cell.sv
rtl/vlc_ctrl.sv
rtl/versioned_lru_object_cache_core.sv
tb/sv/versioned_lru_object_cache_checker.sv
tb/sv/tb_versioned_lru_object_cache_core.sv
